FILE: sv/lrjs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrjs_pkg
// Shared types, constants and the sine table function for the range jump
// segmenter.
// ----------------------------------------------------------------------------
package lrjs_pkg;

    localparam int RANGE_W   = 16;
    localparam int ANGLE_W   = 16;
    localparam int CFG_W     = 16;
    localparam int COORD_W   = 17;
    localparam int CLUSTER_W = 12;
    localparam int MAG_W     = 15;
    localparam int PROD_W    = 32;
    localparam int CFG_IDX_W = 3;

    // Depth of the queue between the classifying front and the arithmetic back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(16384);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_RANGE = 3'd0,
        CFG_MAX_RANGE = 3'd1,
        CFG_START_ANG = 3'd2,
        CFG_ANG_STEP  = 3'd3,
        CFG_JUMP_THR  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [RANGE_W-1:0] min_range_mm;
        logic [RANGE_W-1:0] max_range_mm;
        logic [ANGLE_W-1:0] start_angle;
        logic [ANGLE_W-1:0] angle_step;
        logic [RANGE_W-1:0] jump_threshold_mm;
    } t_cfg;

    // One kept beam as it travels from the front to the back.
    typedef struct packed {
        logic [RANGE_W-1:0]   range_mm;
        logic [ANGLE_W-1:0]   angle;
        logic [CLUSTER_W-1:0] cluster_index;
        logic                 opens_cluster;
    } t_item;

    // Sine of r quarter-table steps, 1.15, from a degree-9 Taylor series in Q30.
    // Only ever called with constant arguments to build the table.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned r,
                                                      input int unsigned tb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q;
        x  = (64'(r) * Q30_HALF_PI) >> (tb - 2);
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        q  = (s + 64'd16384) >> 15;
        return (q > 64'd32767) ? MAG_W'(32767) : q[MAG_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: sv/lrjs_beam_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrjs_beam_if
// Valid/ready channel carrying one laser beam range per beat.
// ----------------------------------------------------------------------------
interface lrjs_beam_if;
    logic                         valid;
    logic                         ready;
    logic [lrjs_pkg::RANGE_W-1:0] range_mm;
    logic                         first_beam;

    modport source (output valid, output range_mm, output first_beam, input ready);
    modport sink   (input valid, input range_mm, input first_beam, output ready);
endinterface
`default_nettype wire

FILE: sv/lrjs_point_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrjs_point_if
// Valid/ready channel carrying one segmented cartesian point per beat.
// ----------------------------------------------------------------------------
interface lrjs_point_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lrjs_pkg::COORD_W-1:0]   x_mm;
    logic signed [lrjs_pkg::COORD_W-1:0]   y_mm;
    logic        [lrjs_pkg::CLUSTER_W-1:0] cluster_index;
    logic                                  opens_cluster;

    modport source (output valid, output x_mm, output y_mm, output cluster_index,
                    output opens_cluster, input ready);
    modport sink   (input valid, input x_mm, input y_mm, input cluster_index,
                    input opens_cluster, output ready);
endinterface
`default_nettype wire

FILE: sv/lidar_range_jump_segmenter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_range_jump_segmenter
// Turns a stream of laser ranges into cartesian points grouped into clusters
// by range jumps.
// ----------------------------------------------------------------------------
// The block takes one beam per cycle while its queue has room and gives at
// most one point per beam. A beam is accepted in the cycle in which it is
// offered, with no extra wait, as long as the four-entry queue behind the
// front is not full; the front does its range gate, jump test and cluster
// count in the accepting cycle, so the scan recurrence never holds up the
// stream. Kept beams leave the queue into a three-stage pipeline (table
// lookup, multiply, rounding), whose last stage is the output register.
// Rejected beams give no point but still advance the beam angle and the
// previous range. Back-pressure on the point channel fills the pipeline and
// then the queue; only then does the beam channel drop ready. Configuration
// is written through a plain write port and must only change while the block
// is idle. The sine table holds 2^(TRIG_TABLE_BITS-2)+1 entries and is built
// as constant logic at elaboration.
// ----------------------------------------------------------------------------
module lidar_range_jump_segmenter #(
    parameter int CLUSTER_INDEX_BITS = 12,
    parameter int TRIG_TABLE_BITS    = 10
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [lrjs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [lrjs_pkg::CFG_W-1:0]        i_cfg_data,
    lrjs_beam_if.sink                         i_beam,
    lrjs_point_if.source                      o_point
);

    // Configuration registers, written one at a time by index.
    lrjs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_range_mm      <= '0;
            r_cfg.max_range_mm      <= '1;
            r_cfg.start_angle       <= '0;
            r_cfg.angle_step        <= '0;
            r_cfg.jump_threshold_mm <= lrjs_pkg::RANGE_W'(500);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lrjs_pkg::CFG_MIN_RANGE: begin
                    r_cfg.min_range_mm <= i_cfg_data;
                end
                lrjs_pkg::CFG_MAX_RANGE: begin
                    r_cfg.max_range_mm <= i_cfg_data;
                end
                lrjs_pkg::CFG_START_ANG: begin
                    r_cfg.start_angle <= i_cfg_data;
                end
                lrjs_pkg::CFG_ANG_STEP: begin
                    r_cfg.angle_step <= i_cfg_data;
                end
                lrjs_pkg::CFG_JUMP_THR: begin
                    r_cfg.jump_threshold_mm <= i_cfg_data;
                end
                default: begin
                    // Writes to unused indexes are ignored.
                end
            endcase
        end
    end

    // Front to queue.
    logic            w_q_full;
    logic            w_push;
    lrjs_pkg::t_item w_push_item;

    // Queue to back.
    logic            w_q_valid;
    logic            w_q_pop;
    lrjs_pkg::t_item w_q_item;

    // The front classifies each beat and updates the scan state in the same
    // cycle; only kept beams are pushed.
    lrjs_front #(
        .CLUSTER_INDEX_BITS (CLUSTER_INDEX_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_beam.valid),
        .i_range_mm   (i_beam.range_mm),
        .i_first_beam (i_beam.first_beam),
        .o_ready      (i_beam.ready),
        .i_q_full     (w_q_full),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    // The queue decouples the two sides: the beam side sees only the queue's
    // full flag, never the point channel's ready.
    lrjs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // The back converts polar to cartesian with rounding half away from zero.
    lrjs_back #(
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_item        (w_q_item),
        .o_q_pop         (w_q_pop),
        .o_valid         (o_point.valid),
        .i_ready         (o_point.ready),
        .o_x_mm          (o_point.x_mm),
        .o_y_mm          (o_point.y_mm),
        .o_cluster_index (o_point.cluster_index),
        .o_opens_cluster (o_point.opens_cluster)
    );

endmodule
`default_nettype wire

FILE: sv/lrjs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrjs_front
// Accepts beams, applies the range gate and jump test, and pushes kept beams
// into the queue with their angle and cluster number.
// ----------------------------------------------------------------------------
module lrjs_front #(
    parameter int CLUSTER_INDEX_BITS = 12
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  lrjs_pkg::t_cfg                     i_cfg,
    input  wire                                i_valid,
    input  wire  [lrjs_pkg::RANGE_W-1:0]       i_range_mm,
    input  wire                                i_first_beam,
    output logic                               o_ready,
    input  wire                                i_q_full,
    output logic                               o_push,
    output lrjs_pkg::t_item                    o_item
);

    logic [lrjs_pkg::RANGE_W-1:0] r_prev_range, n_prev_range;
    logic [lrjs_pkg::ANGLE_W-1:0] r_beam_angle, n_beam_angle;
    logic [CLUSTER_INDEX_BITS-1:0] r_cluster_cnt, n_cluster_cnt;

    logic                          w_accept;
    logic [lrjs_pkg::ANGLE_W-1:0]  w_angle;
    logic [lrjs_pkg::RANGE_W-1:0]  w_diff;
    logic                          w_in_gate;
    logic                          w_opens;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;

    assign w_angle   = i_first_beam ? i_cfg.start_angle : r_beam_angle;
    assign w_diff    = (i_range_mm >= r_prev_range) ? (i_range_mm - r_prev_range)
                                                    : (r_prev_range - i_range_mm);
    assign w_in_gate = (i_range_mm >= i_cfg.min_range_mm) &&
                       (i_range_mm <= i_cfg.max_range_mm);
    assign w_opens   = i_first_beam || (w_diff >= i_cfg.jump_threshold_mm);

    always_comb begin
        n_prev_range  = r_prev_range;
        n_beam_angle  = r_beam_angle;
        n_cluster_cnt = r_cluster_cnt;
        o_push        = 1'b0;
        if (w_accept) begin
            // The raw range and the angle advance for every beam, kept or not.
            n_prev_range = i_range_mm;
            n_beam_angle = w_angle + i_cfg.angle_step;
            if (i_first_beam) begin
                n_cluster_cnt = '0;
                o_push        = 1'b1;
            end else if (w_in_gate) begin
                o_push = 1'b1;
                if (w_opens && (r_cluster_cnt != '1)) begin
                    n_cluster_cnt = r_cluster_cnt + 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_item.range_mm      = i_range_mm;
        o_item.angle         = w_angle;
        o_item.cluster_index = lrjs_pkg::CLUSTER_W'(n_cluster_cnt);
        o_item.opens_cluster = w_opens;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_range  <= '0;
            r_beam_angle  <= '0;
            r_cluster_cnt <= '0;
        end else begin
            r_prev_range  <= n_prev_range;
            r_beam_angle  <= n_beam_angle;
            r_cluster_cnt <= n_cluster_cnt;
        end
    end

endmodule
`default_nettype wire

FILE: sv/lrjs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrjs_queue
// Short first-in first-out queue of kept beams between front and back.
// ----------------------------------------------------------------------------
module lrjs_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  lrjs_pkg::t_item  i_item,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output lrjs_pkg::t_item  o_item
);

    lrjs_pkg::t_item                r_mem [lrjs_pkg::QUEUE_DEPTH];
    logic [lrjs_pkg::QPTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [lrjs_pkg::QPTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [lrjs_pkg::QCNT_W-1:0]    r_count, n_count;
    logic                           w_do_push;
    logic                           w_do_pop;

    assign o_full    = (r_count == lrjs_pkg::QCNT_W'(lrjs_pkg::QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_item    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = w_do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

FILE: sv/lrjs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrjs_back
// Three-stage elastic pipeline: sine and cosine lookup, range multiply,
// rounding and sign. The last stage is the output register.
// ----------------------------------------------------------------------------
module lrjs_back #(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_q_valid,
    input  lrjs_pkg::t_item                          i_q_item,
    output logic                                     o_q_pop,
    output logic                                     o_valid,
    input  wire                                      i_ready,
    output logic signed [lrjs_pkg::COORD_W-1:0]      o_x_mm,
    output logic signed [lrjs_pkg::COORD_W-1:0]      o_y_mm,
    output logic        [lrjs_pkg::CLUSTER_W-1:0]    o_cluster_index,
    output logic                                     o_opens_cluster
);

    localparam int TB      = TRIG_TABLE_BITS;
    localparam int IDX_W   = TB - 1;
    localparam int QUARTER = 1 << (TB - 2);

    typedef struct packed {
        logic             neg;
        logic [IDX_W-1:0] idx;
    } t_trig_sel;

    // Quarter-wave sine table, built at elaboration.
    logic [lrjs_pkg::MAG_W-1:0] w_sin_tab [QUARTER + 1];

    for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
        assign w_sin_tab[g] = lrjs_pkg::quarter_sine(g, TB);
    end

    // Fold a full-turn table index onto the first quadrant.
    function automatic t_trig_sel fold(input logic [TB-1:0] k);
        t_trig_sel        sel;
        logic [1:0]       quad;
        logic [IDX_W-1:0] rem;
        quad    = k[TB-1 -: 2];
        rem     = {1'b0, k[TB-3:0]};
        sel.neg = quad[1];
        sel.idx = quad[0] ? (IDX_W'(QUARTER) - rem) : rem;
        return sel;
    endfunction

    logic [TB-1:0] w_k_sin;
    logic [TB-1:0] w_k_cos;
    t_trig_sel     w_sel_sin;
    t_trig_sel     w_sel_cos;

    assign w_k_sin   = i_q_item.angle[lrjs_pkg::ANGLE_W-1 -: TB];
    assign w_k_cos   = w_k_sin + TB'(QUARTER);
    assign w_sel_sin = fold(w_k_sin);
    assign w_sel_cos = fold(w_k_cos);

    // Stage 1: magnitudes and signs.
    logic                              r_v1;
    logic [lrjs_pkg::RANGE_W-1:0]      r_s1_range;
    logic [lrjs_pkg::MAG_W-1:0]        r_s1_smag, r_s1_cmag;
    logic                              r_s1_sneg, r_s1_cneg;
    logic [lrjs_pkg::CLUSTER_W-1:0]    r_s1_cluster;
    logic                              r_s1_new;

    // Stage 2: rounded products.
    logic                              r_v2;
    logic [lrjs_pkg::PROD_W-1:0]       r_s2_xp, r_s2_yp;
    logic                              r_s2_sneg, r_s2_cneg;
    logic [lrjs_pkg::CLUSTER_W-1:0]    r_s2_cluster;
    logic                              r_s2_new;

    // Stage 3: output register.
    logic                              r_v3;

    logic w_rdy1, w_rdy2, w_rdy3;
    logic [lrjs_pkg::COORD_W-1:0] w_xm, w_ym;

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_q_pop = i_q_valid && w_rdy1;
    assign o_valid = r_v3;

    assign w_xm = r_s2_xp[lrjs_pkg::PROD_W-1 -: lrjs_pkg::COORD_W];
    assign w_ym = r_s2_yp[lrjs_pkg::PROD_W-1 -: lrjs_pkg::COORD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_q_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_range   <= i_q_item.range_mm;
            r_s1_smag    <= w_sin_tab[w_sel_sin.idx];
            r_s1_cmag    <= w_sin_tab[w_sel_cos.idx];
            r_s1_sneg    <= w_sel_sin.neg;
            r_s1_cneg    <= w_sel_cos.neg;
            r_s1_cluster <= i_q_item.cluster_index;
            r_s1_new     <= i_q_item.opens_cluster;
        end
        if (w_rdy2 && r_v1) begin
            r_s2_xp      <= lrjs_pkg::PROD_W'(r_s1_range) * lrjs_pkg::PROD_W'(r_s1_cmag)
                            + lrjs_pkg::ROUND_HALF;
            r_s2_yp      <= lrjs_pkg::PROD_W'(r_s1_range) * lrjs_pkg::PROD_W'(r_s1_smag)
                            + lrjs_pkg::ROUND_HALF;
            r_s2_sneg    <= r_s1_sneg;
            r_s2_cneg    <= r_s1_cneg;
            r_s2_cluster <= r_s1_cluster;
            r_s2_new     <= r_s1_new;
        end
        if (w_rdy3 && r_v2) begin
            o_x_mm          <= r_s2_cneg ? -$signed(w_xm) : $signed(w_xm);
            o_y_mm          <= r_s2_sneg ? -$signed(w_ym) : $signed(w_ym);
            o_cluster_index <= r_s2_cluster;
            o_opens_cluster <= r_s2_new;
        end
    end

endmodule
`default_nettype wire

FILE: verif/lrjs_point_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrjs_point_checker
// Watches the beam, point and register channels of the range jump segmenter,
// predicts each point from its own copy of the scan state and compares it.
// ----------------------------------------------------------------------------
module lrjs_point_checker #(
    parameter int CLUSTER_INDEX_BITS = 12,
    parameter int TRIG_TABLE_BITS    = 10
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [lrjs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [lrjs_pkg::CFG_W-1:0]      i_cfg_data,
    lrjs_beam_if                            i_beam,
    lrjs_point_if                           i_point,
    output int                              o_fault_count,
    output int                              o_points_owed
);
    import lrjs_pkg::*;

    localparam logic [63:0] Q30_UNIT    = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int          QUARTER     = 1 << (TRIG_TABLE_BITS - 2);
    localparam logic [CLUSTER_INDEX_BITS-1:0] CLUSTER_TOP = '1;

    typedef struct packed {
        logic signed [COORD_W-1:0]   x_mm;
        logic signed [COORD_W-1:0]   y_mm;
        logic        [CLUSTER_W-1:0] cluster_index;
        logic                        opens_cluster;
    } t_seg_point;

    // Register copies.
    logic [RANGE_W-1:0] gate_lo;
    logic [RANGE_W-1:0] gate_hi;
    logic [ANGLE_W-1:0] scan_start;
    logic [ANGLE_W-1:0] scan_step;
    logic [RANGE_W-1:0] jump_mm;

    // Scan state.
    logic [RANGE_W-1:0]            last_range;
    logic [ANGLE_W-1:0]            next_angle;
    logic [CLUSTER_INDEX_BITS-1:0] cluster_no;

    t_seg_point expected_points[$];
    int         faults = 0;

    // Sine in 1.15 of idx steps of the first quadrant, from a Taylor series
    // evaluated innermost term first in Q30.
    function automatic logic [MAG_W-1:0] quadrant_sine(input int unsigned idx);
        logic [63:0] arg;
        logic [63:0] arg_sq;
        logic [63:0] poly;
        logic [63:0] prod;
        int          divisors[3];
        divisors = '{42, 20, 6};
        arg    = (64'(idx) * HALF_PI_Q30) >> (TRIG_TABLE_BITS - 2);
        arg_sq = (arg * arg) >> 30;
        poly   = Q30_UNIT - arg_sq / 64'd72;
        foreach (divisors[i])
            poly = Q30_UNIT - ((arg_sq * poly) >> 30) / 64'(divisors[i]);
        prod = (((arg * poly) >> 30) + 64'd16384) >> 15;
        return (prod > 64'd32767) ? MAG_W'(32767) : prod[MAG_W-1:0];
    endfunction

    // Magnitude and sign of the sine at table step k of a full turn.
    function automatic logic [MAG_W-1:0] turn_sine(input int unsigned k, output logic neg);
        int unsigned step;
        int unsigned quad;
        int unsigned rem;
        step = k & ((1 << TRIG_TABLE_BITS) - 1);
        quad = step >> (TRIG_TABLE_BITS - 2);
        rem  = step & (QUARTER - 1);
        neg  = (quad >= 2);
        return quadrant_sine(quad[0] ? QUARTER - rem : rem);
    endfunction

    // Range times a 1.15 factor, rounded half away from zero.
    function automatic logic signed [COORD_W-1:0] to_mm(input logic [RANGE_W-1:0] rng,
                                                        input logic [MAG_W-1:0] mag,
                                                        input logic neg);
        logic [31:0] m;
        m = (32'(rng) * 32'(mag) + 32'd16384) >> 15;
        return neg ? COORD_W'(-m) : COORD_W'(m);
    endfunction

    task automatic log_fault(input string text);
        faults++;
        if (faults <= 10)
            $display("%t %s", $realtime, text);
    endtask

    always @(posedge i_clk) begin : watch
        t_seg_point  got;
        t_seg_point  want;
        logic [RANGE_W-1:0] rng;
        logic [ANGLE_W-1:0] ang;
        logic [RANGE_W-1:0] diff;
        logic        keep;
        logic        opens;
        logic        sneg;
        logic        cneg;
        logic [MAG_W-1:0] smag;
        logic [MAG_W-1:0] cmag;
        int unsigned k;
        if (!i_rst_n) begin
            gate_lo    = '0;
            gate_hi    = '1;
            scan_start = '0;
            scan_step  = '0;
            jump_mm    = RANGE_W'(500);
            last_range = '0;
            next_angle = '0;
            cluster_no = '0;
            expected_points.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MIN_RANGE: gate_lo    = i_cfg_data;
                    CFG_MAX_RANGE: gate_hi    = i_cfg_data;
                    CFG_START_ANG: scan_start = i_cfg_data;
                    CFG_ANG_STEP:  scan_step  = i_cfg_data;
                    CFG_JUMP_THR:  jump_mm    = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_point.valid && i_point.ready) begin
                got = '{i_point.x_mm, i_point.y_mm, i_point.cluster_index,
                        i_point.opens_cluster};
                if (expected_points.size() == 0) begin
                    log_fault($sformatf("unexpected point x=%0d y=%0d cluster=%0d opens=%0b",
                                        got.x_mm, got.y_mm, got.cluster_index,
                                        got.opens_cluster));
                end else begin
                    want = expected_points.pop_front();
                    if (got.x_mm !== want.x_mm || got.y_mm !== want.y_mm ||
                        got.cluster_index !== want.cluster_index ||
                        got.opens_cluster !== want.opens_cluster)
                        log_fault($sformatf({"point mismatch: expected x=%0d y=%0d ",
                                             "cluster=%0d opens=%0b, got x=%0d y=%0d ",
                                             "cluster=%0d opens=%0b"},
                                            want.x_mm, want.y_mm, want.cluster_index,
                                            want.opens_cluster, got.x_mm, got.y_mm,
                                            got.cluster_index, got.opens_cluster));
                end
            end

            if (i_beam.valid && i_beam.ready) begin
                rng = i_beam.range_mm;
                if (i_beam.first_beam) begin
                    ang        = scan_start;
                    cluster_no = '0;
                    opens      = 1'b1;
                    keep       = 1'b1;
                end else begin
                    ang  = next_angle;
                    keep = (rng >= gate_lo) && (rng <= gate_hi);
                    diff = (rng >= last_range) ? rng - last_range : last_range - rng;
                    opens = (diff >= jump_mm);
                    if (keep && opens && cluster_no != CLUSTER_TOP)
                        cluster_no = cluster_no + 1'b1;
                end
                if (keep) begin
                    k    = ang >> (ANGLE_W - TRIG_TABLE_BITS);
                    smag = turn_sine(k, sneg);
                    cmag = turn_sine(k + QUARTER, cneg);
                    want = '{to_mm(rng, cmag, cneg), to_mm(rng, smag, sneg),
                             CLUSTER_W'(cluster_no), opens};
                    expected_points.insert(expected_points.size(), want);
                end
                last_range = rng;
                next_angle = ang + scan_step;
            end
        end
        o_fault_count <= faults;
        o_points_owed <= expected_points.size();
    end

endmodule

FILE: verif/lidar_range_jump_segmenter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_range_jump_segmenter_tb
// Drives laser scans into the range jump segmenter under several register
// settings and random back-pressure; a separate checker predicts every point.
// ----------------------------------------------------------------------------
module lidar_range_jump_segmenter_tb;
    import lrjs_pkg::*;

    // The run is bounded by a cycle counter. The slowest legal run, with
    // every beat waiting out both the sender's gaps and the receiver's stalls,
    // stays far below this figure.
    localparam int CYCLE_LIMIT    = 60000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_BEAMS    = 85;
    localparam int RANDOM_PHASES  = 8;
    localparam int IDLE_PCT       = 35;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    t_cfg_idx           cfg_idx;
    logic [CFG_W-1:0]   cfg_data;

    lrjs_beam_if  beam ();
    lrjs_point_if point ();

    int fault_count;
    int points_owed;

    // Traffic controls shared between the stimulus and the receiver process.
    // Each variable has exactly one writer.
    int  src_idle_pct;
    int  sink_idle_pct;
    bit  hold_req;
    bit  hold_done;
    bit  offering;
    int  cycle_count;

    // What the stimulus knows of the current scan, used to steer the ranges
    // around the jump threshold.
    int                 last_range;
    logic [RANGE_W-1:0] thr_now;

    lidar_range_jump_segmenter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_beam     (beam),
        .o_point    (point)
    );

    lrjs_point_checker checker_u (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_beam        (beam),
        .i_point       (point),
        .o_fault_count (fault_count),
        .o_points_owed (points_owed)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lidar_range_jump_segmenter_tb: FAIL");
            $finish;
        end
    end

    // Point receiver. It normally drops ready at random; once asked, it holds
    // ready low for a long counted stretch so that the pipeline and the queue
    // behind the front fill up and the beam channel is throttled.
    initial begin
        int held;
        point.ready = 1'b0;
        hold_done   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                point.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge i_clk);
                hold_done = 1'b1;
            end
            point.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Offers one beat and returns once it is taken and any gap after it has
    // passed. Valid is left high when no gap follows, so back-to-back beats
    // never see valid lowered and raised within the same time step. Each gap
    // cycle is drawn with the idle percentage, so the sender idles in about
    // that share of its cycles.
    task automatic send_beam(input logic [RANGE_W-1:0] rng, input logic first);
        beam.valid      <= 1'b1;
        beam.range_mm   <= rng;
        beam.first_beam <= first;
        offering = 1'b1;
        do @(posedge i_clk); while (!beam.ready);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            beam.valid <= 1'b0;
            offering = 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
    endtask

    // Stops offering and waits until every predicted point has arrived. The
    // extra cycles before the loop let the checker's registered count take in
    // the last beat, since a rejected beam leaves no point behind to wait for.
    task automatic wait_idle();
        if (offering) begin
            beam.valid <= 1'b0;
            offering = 1'b0;
        end
        repeat (2) @(posedge i_clk);
        while (points_owed != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes all five registers; only ever called with the block idle.
    task automatic set_config(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                              input logic [CFG_W-1:0] start, input logic [CFG_W-1:0] step,
                              input logic [CFG_W-1:0] thr);
        write_reg(CFG_MIN_RANGE, lo);
        write_reg(CFG_MAX_RANGE, hi);
        write_reg(CFG_START_ANG, start);
        write_reg(CFG_ANG_STEP, step);
        write_reg(CFG_JUMP_THR, thr);
        thr_now = thr;
    endtask

    // A random setting per phase, with each register pushed to its extreme
    // now and then.
    task automatic random_config();
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        logic [CFG_W-1:0] start;
        logic [CFG_W-1:0] step;
        logic [CFG_W-1:0] thr;
        int               pick;
        lo    = ($urandom_range(0, 3) == 0) ? '0 : CFG_W'($urandom_range(0, 3000));
        hi    = ($urandom_range(0, 3) == 0) ? '1 : CFG_W'($urandom_range(20000, 65535));
        start = ($urandom_range(0, 4) == 0) ? '1 : CFG_W'($urandom);
        pick  = $urandom_range(0, 9);
        step  = (pick == 0) ? '0 : (pick == 1) ? '1 : CFG_W'($urandom);
        pick  = $urandom_range(0, 9);
        thr   = (pick < 2) ? '0 : (pick == 2) ? '1 : CFG_W'($urandom_range(1, 8000));
        set_config(lo, hi, start, step, thr);
    endtask

    // One scan: a first beam followed by beams that mostly walk around the
    // previous range by steps near the jump threshold, with some noise beats
    // that may carry a stray first-beam flag. Returns the number of beats.
    task automatic run_scan(input int len, output int sent);
        int r;
        int delta;
        int spread;
        int i;
        r = $urandom_range(0, 65535);
        send_beam(r[RANGE_W-1:0], 1'b1);
        last_range = r;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 12) begin
                r = $urandom_range(0, 65535);
                send_beam(r[RANGE_W-1:0], $urandom_range(0, 7) == 0);
            end else begin
                spread = (thr_now == 0) ? 64 : 2 * int'(thr_now);
                if ($urandom_range(0, 4) == 0)
                    delta = int'(thr_now) + $urandom_range(0, 2) - 1;
                else
                    delta = $urandom_range(0, spread);
                r = ($urandom_range(0, 1) == 1) ? last_range + delta : last_range - delta;
                if (r < 0)
                    r = 0;
                if (r > 65535)
                    r = 65535;
                send_beam(r[RANGE_W-1:0], 1'b0);
            end
            last_range = r;
        end
        sent = len + 1;
    endtask

    initial begin
        int phase;
        int phase_sent;
        int sent;
        int i;

        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_MIN_RANGE;
        cfg_data        = '0;
        beam.valid      = 1'b0;
        beam.range_mm   = '0;
        beam.first_beam = 1'b0;
        src_idle_pct    = IDLE_PCT;
        sink_idle_pct   = IDLE_PCT;
        hold_req        = 1'b0;
        offering        = 1'b0;
        thr_now         = RANGE_W'(500);
        last_range      = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Beams before any first beam run on the reset state: angle zero,
        // cluster zero, previous range zero and the reset registers.
        send_beam(16'd1000, 1'b0);
        send_beam(16'd1200, 1'b0);
        send_beam(16'd0, 1'b0);
        wait_idle();

        // Range gate edges and the jump test on, just under and over the
        // threshold. The first beam is kept although it lies below the gate.
        set_config(16'd100, 16'd60000, 16'h1234, 16'h0400, 16'd300);
        send_beam(16'd0, 1'b1);
        send_beam(16'd99, 1'b0);
        send_beam(16'd100, 1'b0);
        send_beam(16'd400, 1'b0);
        send_beam(16'd699, 1'b0);
        send_beam(16'd60000, 1'b0);
        send_beam(16'd60001, 1'b0);
        send_beam(16'd59000, 1'b0);
        wait_idle();

        // Full range on all four axes with a quarter-turn step, so the angle
        // wraps; the largest threshold opens a cluster only on the full jump.
        set_config(16'd0, 16'hFFFF, 16'h0000, 16'h4000, 16'hFFFF);
        send_beam(16'hFFFF, 1'b1);
        send_beam(16'hFFFF, 1'b0);
        send_beam(16'hFFFF, 1'b0);
        send_beam(16'hFFFF, 1'b0);
        send_beam(16'd0, 1'b0);
        wait_idle();

        // Minimum above maximum: only the first beam gets through.
        set_config(16'd5000, 16'd4000, 16'hFFFF, 16'hFFFF, 16'd0);
        send_beam(16'd4500, 1'b1);
        send_beam(16'd4500, 1'b0);
        send_beam(16'd100, 1'b0);
        send_beam(16'hFFFF, 1'b0);
        wait_idle();

        // Zero threshold: every kept beam opens a cluster, even on no change.
        set_config(16'd0, 16'hFFFF, 16'h8000, 16'h0123, 16'd0);
        send_beam(16'd2000, 1'b1);
        send_beam(16'd2000, 1'b0);
        send_beam(16'd2000, 1'b0);
        send_beam(16'd3000, 1'b0);
        wait_idle();

        // Random phases. The third one runs with no idling on either side.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_config();
            src_idle_pct  = (phase == 2) ? 0 : IDLE_PCT;
            sink_idle_pct = (phase == 2) ? 0 : IDLE_PCT;
            phase_sent = 0;
            while (phase_sent < PHASE_BEAMS) begin
                run_scan($urandom_range(1, 30), sent);
                phase_sent += sent;
            end
            wait_idle();

            // Midway, the receiver stalls for a long stretch while the sender
            // keeps offering back-to-back beats that are all kept.
            if (phase == 4) begin
                set_config(16'd0, 16'hFFFF, CFG_W'($urandom), CFG_W'($urandom), 16'd1000);
                src_idle_pct = 0;
                hold_req     = 1'b1;
                for (i = 0; i < 40; i++)
                    send_beam(RANGE_W'($urandom), i == 0);
                wait_idle();
                src_idle_pct = IDLE_PCT;
            end
        end

        if (fault_count == 0 && points_owed == 0) begin
            $display("lidar_range_jump_segmenter_tb: PASS");
        end else begin
            $display("lidar_range_jump_segmenter_tb: FAIL");
        end
        $finish;
    end

endmodule
